>>> hdl/prc_pkg.sv
package prc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NUM_STAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

	localparam int FRAC_BITS = 12;
	localparam int DW = 32;

	// Gain correction 1/K as an unsigned fraction of 2^32.
	localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;
	localparam int PROD_W = 65;
	localparam int RND_SHIFT = 32 + FRAC_BITS;

	localparam logic MODE_POLAR = 1'b0;
	localparam logic MODE_CART = 1'b1;

	localparam logic REG_MODE = 1'b0;

	typedef struct packed {
		logic                 vec;
		logic                 zero;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic [DW-1:0]        z;
	} vec_t;

	function automatic logic [31:0] atan_angle(input int idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/prc_pre.sv
module prc_pre (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                mode,
	input  logic signed [15:0]  in_first,
	input  logic signed [15:0]  in_second,
	output logic                vld_s1,
	output prc_pkg::vec_t       data_s1
);

	logic signed [16:0] a;
	logic signed [16:0] b;
	logic signed [16:0] a_c;
	logic signed [16:0] b_c;
	logic [31:0]        z_p;
	prc_pkg::vec_t      nxt;

	always_comb begin
		a = {in_first[15], in_first};
		b = {in_second[15], in_second};
		a_c = a;
		b_c = b;
		nxt.vec = mode;
		nxt.zero = 1'b0;
		nxt.y = '0;
		nxt.z = '0;
		if (mode == prc_pkg::MODE_POLAR) begin
			// Angles outside +-pi/2 are turned by pi, which mirrors the radius.
			z_p = {in_second, 16'h0000};
			if (in_second > 16'sd16384 || in_second < -16'sd16384) begin
				z_p = z_p ^ 32'h8000_0000;
				a_c = -a;
			end
			nxt.z = z_p;
		end else begin
			z_p = '0;
			nxt.zero = (in_first == 16'sd0) && (in_second == 16'sd0);
			// Left half plane: rotate by pi first and add pi back to the angle.
			if (a < 0) begin
				a_c = -a;
				b_c = -b;
				nxt.z = 32'h8000_0000;
			end
			nxt.y = {{3{b_c[16]}}, b_c, {prc_pkg::FRAC_BITS{1'b0}}};
		end
		nxt.x = {{3{a_c[16]}}, a_c, {prc_pkg::FRAC_BITS{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

>>> hdl/prc_cordic.sv
module prc_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  prc_pkg::vec_t data_in,
	output logic          vld_out,
	output prc_pkg::vec_t data_out
);

	logic          rot_vld_s [0:prc_pkg::NUM_STAGES];
	prc_pkg::vec_t rot_s     [0:prc_pkg::NUM_STAGES];

	assign rot_vld_s[0] = vld_in;
	assign rot_s[0] = data_in;

	for (genvar i = 0; i < prc_pkg::NUM_STAGES; i++) begin : g_rot
		localparam logic [31:0] ANG = prc_pkg::atan_angle(i);
		prc_pkg::vec_t nxt;
		logic          up;

		always_comb begin
			nxt = rot_s[i];
			if (rot_s[i].vec == prc_pkg::MODE_CART) begin
				up = (rot_s[i].y <= 0);
			end else begin
				up = !rot_s[i].z[31];
			end
			if (up) begin
				nxt.x = rot_s[i].x - (rot_s[i].y >>> i);
				nxt.y = rot_s[i].y + (rot_s[i].x >>> i);
				nxt.z = rot_s[i].z - ANG;
			end else begin
				nxt.x = rot_s[i].x + (rot_s[i].y >>> i);
				nxt.y = rot_s[i].y - (rot_s[i].x >>> i);
				nxt.z = rot_s[i].z + ANG;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_vld_s[i+1] <= 1'b0;
			end else begin
				rot_vld_s[i+1] <= rot_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rot_s[i+1] <= nxt;
		end
	end

	assign vld_out = rot_vld_s[prc_pkg::NUM_STAGES];
	assign data_out = rot_s[prc_pkg::NUM_STAGES];

endmodule

>>> hdl/prc_gain.sv
module prc_gain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  prc_pkg::vec_t       data_in,
	output logic                done,
	output logic signed [16:0]  out_first,
	output logic signed [16:0]  out_second
);

	localparam logic signed [prc_pkg::PROD_W-1:0] HALF =
		prc_pkg::PROD_W'(1) <<< (prc_pkg::RND_SHIFT - 1);

	logic                               vld_s1;
	logic                               vec_s1;
	logic                               zero_s1;
	logic signed [prc_pkg::PROD_W-1:0]  px_s1;
	logic signed [prc_pkg::PROD_W-1:0]  py_s1;
	logic [15:0]                        ang_s1;
	logic [31:0]                        z_rnd;
	logic signed [prc_pkg::PROD_W-1:0]  rx;
	logic signed [prc_pkg::PROD_W-1:0]  ry;
	logic signed [16:0]                 first_d;
	logic signed [16:0]                 second_d;
	logic                               done_s2;
	logic signed [16:0]                 first_s2;
	logic signed [16:0]                 second_s2;

	assign z_rnd = data_in.z + 32'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= data_in.vec;
		zero_s1 <= data_in.zero;
		px_s1 <= data_in.x * $signed({1'b0, prc_pkg::GAIN_Q32});
		py_s1 <= data_in.y * $signed({1'b0, prc_pkg::GAIN_Q32});
		ang_s1 <= z_rnd[31:16];
	end

	// Round half up, then keep the low 17 bits of the floored quotient.
	always_comb begin
		rx = px_s1 + HALF;
		ry = py_s1 + HALF;
		first_d = rx[prc_pkg::RND_SHIFT +: 17];
		if (vec_s1 == prc_pkg::MODE_CART) begin
			second_d = {ang_s1[15], ang_s1};
		end else begin
			second_d = ry[prc_pkg::RND_SHIFT +: 17];
		end
		if (zero_s1) begin
			first_d = '0;
			second_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_d;
		second_s2 <= second_d;
	end

	assign done = done_s2;
	assign out_first = first_s2;
	assign out_second = second_s2;

endmodule

>>> hdl/polar_rectangular_converter_core.sv
// Channel   Signals                                   Transfer
// input     start, busy, in_first, in_second          start high while busy low
// result    done, out_first, out_second               done high for one cycle
// config    psel, penable, pwrite, paddr, pwdata,     psel, penable, pwrite, pready
//           prdata, pready                            all high; mode at byte 0
//
// One vector enters per cycle; its result passes through one conditioning stage,
// one per micro-rotation, one for the gain multiply and one for rounding.
// busy is always low and nothing stalls.
// Reset clears the valid bits and sets the mode to polar to Cartesian.
module polar_rectangular_converter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  in_first,
	input  logic signed [15:0]  in_second,
	output logic                done,
	output logic signed [16:0]  out_first,
	output logic signed [16:0]  out_second,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic          mode_q;
	logic          vld_s1;
	prc_pkg::vec_t data_s1;
	logic          rot_vld;
	prc_pkg::vec_t rot_data;

	assign busy = 1'b0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= prc_pkg::MODE_POLAR;
		end else if (psel && penable && pwrite && paddr[2] == prc_pkg::REG_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == prc_pkg::REG_MODE) ? {31'b0, mode_q} : 32'b0;

	prc_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (start && !busy),
		.mode      (mode_q),
		.in_first  (in_first),
		.in_second (in_second),
		.vld_s1    (vld_s1),
		.data_s1   (data_s1)
	);

	prc_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s1),
		.data_in  (data_s1),
		.vld_out  (rot_vld),
		.data_out (rot_data)
	);

	prc_gain u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (rot_vld),
		.data_in    (rot_data),
		.done       (done),
		.out_first  (out_first),
		.out_second (out_second)
	);

endmodule

>>> bench/polar_rectangular_converter_core_tb.sv
`timescale 1ns / 1ps

module polar_rectangular_converter_core_tb;
	import prc_pkg::*;

	localparam int LATENCY = NUM_STAGES + 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PERCENT = 14;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_VECTORS = 220;
	localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};
	localparam logic [2:0] UNUSED_ADDR = 3'd4;
	localparam longint HALF_TURN = 64'sd2147483648;
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint GAIN = {32'd0, GAIN_Q32};

	typedef struct {
		logic signed [15:0] first_in;
		logic signed [15:0] second_in;
		logic               mode;
		logic [16:0]        first;
		logic [16:0]        second;
	} vector_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] in_first;
	logic signed [15:0] in_second;
	logic               done;
	logic signed [16:0] out_first;
	logic signed [16:0] out_second;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Micro-rotation angles as binary angles, 2^31 = pi.
	longint atan_step [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	vector_result_t pending_vectors [$];
	vector_result_t head;
	logic           mode_shadow;
	bit             idle_on;
	int             error_count = 0;
	int             cycle_count = 0;

	polar_rectangular_converter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_first(in_first),
		.in_second(in_second),
		.done(done),
		.out_first(out_first),
		.out_second(out_second),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void cordic_pass(inout longint x, inout longint y, inout longint z,
			input bit vectoring);
		longint dx;
		longint dy;
		bit     up;
		for (int i = 0; i < NUM_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			up = vectoring ? (y <= 0) : (z >= 0);
			if (up) begin
				x -= dx;
				y += dy;
				z -= atan_step[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_step[i];
			end
		end
	endfunction

	// Undo the CORDIC gain and round the fraction bits off.
	function automatic longint scale_round(input longint v);
		return (v * GAIN + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
	endfunction

	function automatic void convert_vector(input logic mode, input logic signed [15:0] first_in,
			input logic signed [15:0] second_in, output logic [16:0] first_out,
			output logic [16:0] second_out);
		longint a;
		longint b;
		longint x;
		longint y;
		longint z;
		longint xr;
		longint yr;
		a = first_in;
		b = second_in;
		first_out = '0;
		second_out = '0;
		if (mode == MODE_POLAR) begin
			// Angles past a quarter turn are folded back and the radius mirrored.
			z = b * 65536;
			if (z > QUARTER_TURN) begin
				z -= HALF_TURN;
				a = -a;
			end else if (z < -QUARTER_TURN) begin
				z += HALF_TURN;
				a = -a;
			end
			x = a * (longint'(1) <<< FRAC_BITS);
			y = 0;
			cordic_pass(x, y, z, 1'b0);
			xr = scale_round(x);
			yr = scale_round(y);
			first_out = xr[16:0];
			second_out = yr[16:0];
		end else if (a != 0 || b != 0) begin
			// The left half plane is turned by pi first, and pi is added back.
			z = 0;
			if (a < 0) begin
				a = -a;
				b = -b;
				z = HALF_TURN;
			end
			x = a * (longint'(1) <<< FRAC_BITS);
			y = b * (longint'(1) <<< FRAC_BITS);
			cordic_pass(x, y, z, 1'b1);
			xr = scale_round(x);
			yr = (z + 32768) >>> 16;
			first_out = xr[16:0];
			second_out = {yr[15], yr[15:0]};
		end
	endfunction

	function automatic logic signed [15:0] random_coord();
		logic signed [15:0] v;
		case ($urandom_range(9))
			6, 7: v = 16'($signed($urandom_range(64)) - 32);
			8: begin
				case ($urandom_range(3))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sh0000;
					default: v = 16'shFFFF;
				endcase
			end
			9: v = $urandom_range(1) ? 16'($signed(32767 - $urandom_range(15)))
				: 16'($signed(-32768 + $urandom_range(15)));
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	task automatic send_vector(input logic signed [15:0] a, input logic signed [15:0] b);
		vector_result_t item;
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_first <= a;
		in_second <= b;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		item.first_in = a;
		item.second_in = b;
		item.mode = mode_shadow;
		convert_vector(mode_shadow, a, b, item.first, item.second);
		pending_vectors.push_back(item);
	endtask

	// Stop sending and let every transfer in the pipeline come out.
	task automatic settle();
		start <= 1'b0;
		while (pending_vectors.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == MODE_ADDR)
			mode_shadow = data[0];
		@(posedge clk);
	endtask

	task automatic check_mode_readback();
		logic [31:0] value;
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= MODE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (value[0] !== mode_shadow)
			report_error($sformatf("mode readback: expected %0b, got %0b", mode_shadow, value[0]));
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [31:0] data);
		settle();
		write_reg(MODE_ADDR, data);
	endtask

	task automatic test_polar_directed();
		set_mode({31'h7FFF_FFFF, MODE_POLAR});
		send_vector(16'sd0, 16'sd0);
		send_vector(16'sd32767, 16'sd0);
		send_vector(-16'sd32768, 16'sd0);
		send_vector(16'sd32767, 16'sd16384);
		send_vector(16'sd32767, -16'sd16384);
		send_vector(16'sd32767, -16'sd32768);
		send_vector(16'sd32767, 16'sd32767);
		send_vector(16'sd1000, 16'sd16385);
		send_vector(16'sd1000, -16'sd16385);
		send_vector(-16'sd1, 16'sd8192);
		send_vector(-16'sd32768, -16'sd32768);
	endtask

	task automatic test_cartesian_directed();
		set_mode({31'h0000_0001, MODE_CART});
		send_vector(16'sd0, 16'sd0);
		send_vector(16'sd32767, 16'sd0);
		send_vector(-16'sd32768, 16'sd0);
		send_vector(-16'sd1, 16'sd0);
		send_vector(16'sd0, 16'sd32767);
		send_vector(16'sd0, -16'sd32768);
		send_vector(16'sd32767, 16'sd32767);
		send_vector(-16'sd32768, -16'sd32768);
		send_vector(-16'sd32768, 16'sd32767);
		send_vector(-16'sd100, 16'sd1);
		send_vector(-16'sd1, -16'sd1);
	endtask

	// Upper data bits and writes to other addresses must leave the mode alone.
	task automatic test_register_decode();
		set_mode({31'h52D2_D2D2, MODE_CART});
		check_mode_readback();
		write_reg(UNUSED_ADDR, {31'h0, MODE_POLAR});
		check_mode_readback();
		send_vector(16'sd3, -16'sd4);
		send_vector(-16'sd12, 16'sd5);
		set_mode({31'h2D2D_2D2D, MODE_POLAR});
		check_mode_readback();
		send_vector(16'sd2000, 16'sd24576);
		send_vector(16'sd2000, -16'sd24576);
	endtask

	task automatic test_random();
		logic [31:0] noise;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			noise = $urandom;
			set_mode({noise[31:1], (p % 2 == 1) ? MODE_CART : MODE_POLAR});
			idle_on = (p != 3);
			for (int n = 0; n < PHASE_VECTORS; n++)
				send_vector(random_coord(), random_coord());
			idle_on = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_vectors.size() == 0) begin
				report_error($sformatf("unexpected result: first %0d second %0d",
					out_first, out_second));
			end else begin
				head = pending_vectors.pop_front();
				if (out_first !== head.first || out_second !== head.second)
					report_error($sformatf(
						"mode %0b in (%0d, %0d): expected (%0d, %0d), got (%0d, %0d)",
						head.mode, head.first_in, head.second_in, $signed(head.first),
						$signed(head.second), out_first, out_second));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[polar_rectangular_converter_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		in_first <= '0;
		in_second <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		mode_shadow = MODE_POLAR;
		idle_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_polar_directed();
		test_cartesian_directed();
		test_register_decode();
		test_random();

		settle();
		repeat (4) @(posedge clk);
		if (pending_vectors.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_vectors.size()));
		if (error_count == 0) begin
			$display("[polar_rectangular_converter_core] OK");
		end else begin
			$display("[polar_rectangular_converter_core] ERROR");
		end
		$finish;
	end

endmodule

>>> polar_rectangular_converter_core.f
hdl/prc_pkg.sv
hdl/prc_pre.sv
hdl/prc_cordic.sv
hdl/prc_gain.sv
hdl/polar_rectangular_converter_core.sv
bench/polar_rectangular_converter_core_tb.sv
